>>> rtl/core/trd_pkg.sv
// ----------------------------------------------------------------------------
// trd_pkg - shared types and constants of the TLS record deframer
// Record parser state, result item layout and protocol constants.
// ----------------------------------------------------------------------------
package trd_pkg;

  localparam logic [7:0]  TLS_VER      = 8'h03;
  localparam logic [7:0]  CT_HANDSHAKE = 8'd22;
  localparam logic [7:0]  HT_CERT      = 8'd11;
  localparam int          LOOK_LEN     = 11;
  localparam logic [16:0] HDR_LEN      = 17'd5;
  localparam logic [16:0] CERT_PRE     = 17'd7;

  localparam logic RES_SUMMARY = 1'b0;
  localparam logic RES_CERT    = 1'b1;

  // per-direction record parser state
  typedef struct packed {
    logic [16:0] offset;
    logic [15:0] rlen;
    logic [7:0]  ct;
    logic [7:0]  ht;
    logic [23:0] acc;
    logic [15:0] skip;
    logic [1:0]  nbytes;
  } rec_state_t;

  typedef struct packed {
    logic        kind;
    logic [7:0]  content_type;
    logic [7:0]  handshake_type;
    logic [23:0] length_value;
    logic        overrun;
    logic        last;
  } result_t;

  // parser outcome for one input byte: at most two results
  typedef struct packed {
    rec_state_t  st;
    result_t     r0;
    result_t     r1;
    logic [1:0]  nres;
  } parse_out_t;

  function automatic result_t mk_res(logic kind, logic [7:0] ct, logic [7:0] ht,
                                     logic [23:0] len, logic ov);
    result_t r;
    r.kind           = kind;
    r.content_type   = ct;
    r.handshake_type = ht;
    r.length_value   = len;
    r.overrun        = ov;
    r.last           = 1'b0;
    return r;
  endfunction

endpackage

>>> rtl/core/tls_record_deframer.sv
// ----------------------------------------------------------------------------
// tls_record_deframer - TLS record layer deframer for one connection
// Detects TLS in the payload stream, splits each direction into records and
// reports record summaries and certificate lengths.
// ----------------------------------------------------------------------------
// A byte is registered at its transfer and its results enter the result queue
// in the following cycle; the first is offered once it is queued. One byte is
// taken per cycle while in_ready is high; the parse between the input register
// and the result queue is combinational. in_ready drops while the queue holds
// more than RES_DEPTH-4 results. Synchronous reset clears all control state at
// once; the held lookahead bytes and the queue storage are not cleared.
module tls_record_deframer
  import trd_pkg::*;
#(
  parameter int RES_DEPTH = 8
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  data_byte,
  input  logic        direction,
  input  logic        packet_start,
  output logic        out_valid,
  input  logic        out_ready,
  output logic        result_kind,
  output logic [7:0]  content_type,
  output logic [7:0]  handshake_type,
  output logic [23:0] length_value,
  output logic        overrun,
  output logic        last_result
);

  localparam int PTR_W = $clog2(RES_DEPTH);
  localparam int CNT_W = $clog2(RES_DEPTH + 1);

  localparam logic [1:0] PH_DETECT  = 2'd0;
  localparam logic [1:0] PH_DISCARD = 2'd1;
  localparam logic [1:0] PH_RECORD  = 2'd2;

  // ---------------------------------------------------------------------------
  // Parse one byte of a record stream
  // ---------------------------------------------------------------------------
  function automatic parse_out_t parse_byte(rec_state_t s, logic [7:0] b);
    parse_out_t  p;
    logic [16:0] i;
    logic [7:0]  ht;
    logic        certs;
    logic [23:0] acc_n;
    logic [15:0] left;
    logic [15:0] rl;
    result_t     r;
    p      = '0;
    p.st   = s;
    i      = s.offset - HDR_LEN;
    ht     = s.ht;
    certs  = 1'b0;
    acc_n  = '0;
    left   = '0;
    rl     = '0;
    r      = '0;
    if (s.offset < HDR_LEN) begin
      p.st.offset = s.offset + 17'd1;
      if (s.offset == 17'd0) begin
        p.st.ct     = b;
        p.st.ht     = '0;
        p.st.rlen   = '0;
        p.st.acc    = '0;
        p.st.skip   = '0;
        p.st.nbytes = '0;
      end else if (s.offset == 17'd3) begin
        p.st.rlen = {b, 8'h00};
      end else if (s.offset == 17'd4) begin
        rl        = {s.rlen[15:8], b};
        p.st.rlen = rl;
        if (rl == 16'd0) begin
          p.r0        = mk_res(RES_SUMMARY, s.ct, 8'h00, 24'd0, 1'b0);
          p.nres      = 2'd1;
          p.st.offset = '0;
        end
      end
    end else begin
      if (i == 17'd0) begin
        ht = b;
      end
      p.st.ht = ht;
      certs   = (s.ct == CT_HANDSHAKE) && (ht == HT_CERT);
      if (certs && i >= CERT_PRE) begin
        if (s.skip != 16'd0) begin
          p.st.skip = s.skip - 16'd1;
        end else begin
          acc_n = {s.acc[15:0], b};
          if (s.nbytes == 2'd2) begin
            // bytes left in the record after this one
            left = 16'(({1'b0, s.rlen} - 17'd1) - i);
            if (acc_n > {8'h00, left}) begin
              p.r0      = mk_res(RES_CERT, CT_HANDSHAKE, HT_CERT, {8'h00, left}, 1'b1);
              p.st.skip = left;
            end else begin
              p.r0      = mk_res(RES_CERT, CT_HANDSHAKE, HT_CERT, acc_n, 1'b0);
              p.st.skip = acc_n[15:0];
            end
            p.nres      = 2'd1;
            p.st.acc    = '0;
            p.st.nbytes = '0;
          end else begin
            p.st.acc    = acc_n;
            p.st.nbytes = s.nbytes + 2'd1;
          end
        end
      end
      if (i + 17'd1 >= {1'b0, s.rlen}) begin
        // a length field cut by the record end shows up as an empty overrun
        if (certs && p.st.nbytes != 2'd0) begin
          p.r0   = mk_res(RES_CERT, CT_HANDSHAKE, HT_CERT, 24'd0, 1'b1);
          p.nres = 2'd1;
        end
        r = mk_res(RES_SUMMARY, s.ct, ht, {8'h00, s.rlen}, 1'b0);
        if (p.nres == 2'd0) begin
          p.r0 = r;
        end else begin
          p.r1 = r;
        end
        p.nres      = p.nres + 2'd1;
        p.st.offset = '0;
      end else begin
        p.st.offset = s.offset + 17'd1;
      end
    end
    return p;
  endfunction

  // ---------------------------------------------------------------------------
  // Parse the 11 held bytes of a packet from a fresh record start. No
  // certificate body can be reached within 11 bytes, so only record headers
  // and summaries are resolved here.
  // ---------------------------------------------------------------------------
  function automatic parse_out_t replay(logic [10:0][7:0] x);
    parse_out_t  p;
    logic [15:0] l1;
    logic [15:0] l2;
    logic [15:0] l3;
    p  = '0;
    l1 = {x[3], x[4]};
    l2 = {x[8], x[9]};
    l3 = {x[9], x[10]};
    if (l1 == 16'd0) begin
      p.r0 = mk_res(RES_SUMMARY, x[0], 8'h00, 24'd0, 1'b0);
      if (l2 == 16'd0) begin
        p.r1        = mk_res(RES_SUMMARY, x[5], 8'h00, 24'd0, 1'b0);
        p.nres      = 2'd2;
        p.st.offset = 17'd1;
        p.st.ct     = x[10];
      end else begin
        p.st.ct   = x[5];
        p.st.ht   = x[10];
        p.st.rlen = l2;
        if (l2 == 16'd1) begin
          p.r1        = mk_res(RES_SUMMARY, x[5], x[10], 24'd1, 1'b0);
          p.nres      = 2'd2;
          p.st.offset = 17'd0;
        end else begin
          p.nres      = 2'd1;
          p.st.offset = 17'd6;
        end
      end
    end else if (l1 >= 16'd7) begin
      p.st.offset = 17'd11;
      p.st.ct     = x[0];
      p.st.ht     = x[5];
      p.st.rlen   = l1;
    end else begin
      p.r0   = mk_res(RES_SUMMARY, x[0], x[5], {8'h00, l1}, 1'b0);
      p.nres = 2'd1;
      case (l1[2:0])
        3'd1: begin
          p.st.ct   = x[6];
          p.st.rlen = l3;
          if (l3 == 16'd0) begin
            p.r1        = mk_res(RES_SUMMARY, x[6], 8'h00, 24'd0, 1'b0);
            p.nres      = 2'd2;
            p.st.offset = 17'd0;
          end else begin
            p.st.offset = 17'd5;
          end
        end
        3'd2: begin
          p.st.ct     = x[7];
          p.st.rlen   = {x[10], 8'h00};
          p.st.offset = 17'd4;
        end
        3'd3: begin
          p.st.ct     = x[8];
          p.st.offset = 17'd3;
        end
        3'd4: begin
          p.st.ct     = x[9];
          p.st.offset = 17'd2;
        end
        3'd5: begin
          p.st.ct     = x[10];
          p.st.offset = 17'd1;
        end
        default: begin
          p.st.offset = 17'd0;
        end
      endcase
    end
    return p;
  endfunction

  function automatic logic [PTR_W-1:0] ptr_inc(logic [PTR_W-1:0] q);
    return (q == PTR_W'(RES_DEPTH - 1)) ? '0 : q + PTR_W'(1);
  endfunction

  // ---------------------------------------------------------------------------
  // State
  // ---------------------------------------------------------------------------
  logic             tls_detected;
  logic [1:0]       phase [2];
  logic [3:0]       la_count [2];
  logic [7:0]       la_bytes [2][10];
  rec_state_t       rec [2];

  logic             s1_valid;
  logic [7:0]       s1_byte;
  logic             s1_dir;
  logic             s1_ps;

  result_t          res_mem [RES_DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;

  // ---------------------------------------------------------------------------
  // Parse stage
  // ---------------------------------------------------------------------------
  rec_state_t       cur_st;
  rec_state_t       st_fresh;
  parse_out_t       po;
  logic [1:0]       phase_next;
  logic [3:0]       cnt_next;
  logic             tls_next;
  logic             st_we;
  logic             la_we;
  logic             det;
  logic [10:0][7:0] held;

  always_comb begin
    cur_st   = rec[s1_dir];
    st_fresh = cur_st;
    st_fresh.offset = '0;
    for (int k = 0; k < 10; k++) begin
      held[k] = la_bytes[s1_dir][k];
    end
    held[10]   = s1_byte;
    po         = '0;
    po.st      = cur_st;
    phase_next = phase[s1_dir];
    cnt_next   = la_count[s1_dir];
    tls_next   = tls_detected;
    st_we      = 1'b0;
    la_we      = 1'b0;
    det        = (la_bytes[s1_dir][1] == TLS_VER) && (la_bytes[s1_dir][2] == TLS_VER) &&
                 (la_bytes[s1_dir][9] == TLS_VER) && (s1_byte == TLS_VER);
    if (s1_valid) begin
      if (phase[s1_dir] == PH_RECORD) begin
        po    = parse_byte(cur_st, s1_byte);
        st_we = 1'b1;
      end else begin
        if (s1_ps) begin
          if (tls_detected) begin
            phase_next = PH_RECORD;
          end else begin
            phase_next = PH_DETECT;
            cnt_next   = '0;
          end
        end
        if (phase_next == PH_RECORD) begin
          po    = parse_byte(st_fresh, s1_byte);
          st_we = 1'b1;
        end else if (phase_next == PH_DETECT) begin
          if (cnt_next == 4'(LOOK_LEN - 1)) begin
            tls_next = tls_detected | det;
            cnt_next = '0;
            if (tls_detected | det) begin
              phase_next = PH_RECORD;
              po         = replay(held);
              st_we      = 1'b1;
            end else begin
              phase_next = PH_DISCARD;
            end
          end else begin
            la_we    = 1'b1;
            cnt_next = cnt_next + 4'd1;
          end
        end
      end
    end
    // flag the final result of this byte
    if (po.nres == 2'd1) begin
      po.r0.last = 1'b1;
    end else if (po.nres == 2'd2) begin
      po.r1.last = 1'b1;
    end
  end

  // ---------------------------------------------------------------------------
  // Result queue
  // ---------------------------------------------------------------------------
  logic [PTR_W-1:0] wr_ptr1;
  logic [PTR_W-1:0] wr_ptr_next;
  logic             pop;
  logic [CNT_W-1:0] count_next;

  assign wr_ptr1  = ptr_inc(wr_ptr);
  assign pop      = out_valid && out_ready;
  assign in_ready = (count <= CNT_W'(RES_DEPTH - 4));

  always_comb begin
    case (po.nres)
      2'd1:    wr_ptr_next = wr_ptr1;
      2'd2:    wr_ptr_next = ptr_inc(wr_ptr1);
      default: wr_ptr_next = wr_ptr;
    endcase
    count_next = count + CNT_W'(po.nres) - CNT_W'(pop);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      tls_detected <= 1'b0;
      s1_valid     <= 1'b0;
      wr_ptr       <= '0;
      rd_ptr       <= '0;
      count        <= '0;
      for (int k = 0; k < 2; k++) begin
        phase[k]    <= PH_DETECT;
        la_count[k] <= '0;
        rec[k]      <= '0;
      end
    end else begin
      s1_valid     <= in_valid && in_ready;
      tls_detected <= tls_next;
      if (s1_valid) begin
        phase[s1_dir]    <= phase_next;
        la_count[s1_dir] <= cnt_next;
      end
      if (st_we) begin
        rec[s1_dir] <= po.st;
      end
      wr_ptr <= wr_ptr_next;
      count  <= count_next;
      if (pop) begin
        rd_ptr <= ptr_inc(rd_ptr);
      end
    end
  end

  // payload storage, no reset
  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      s1_byte <= data_byte;
      s1_dir  <= direction;
      s1_ps   <= packet_start;
    end
    if (la_we) begin
      la_bytes[s1_dir][cnt_next - 4'd1] <= s1_byte;
    end
    if (po.nres != 2'd0) begin
      res_mem[wr_ptr] <= po.r0;
    end
    if (po.nres == 2'd2) begin
      res_mem[wr_ptr1] <= po.r1;
    end
  end

  assign out_valid      = (count != '0);
  assign result_kind    = res_mem[rd_ptr].kind;
  assign content_type   = res_mem[rd_ptr].content_type;
  assign handshake_type = res_mem[rd_ptr].handshake_type;
  assign length_value   = res_mem[rd_ptr].length_value;
  assign overrun        = res_mem[rd_ptr].overrun;
  assign last_result    = res_mem[rd_ptr].last;

  // ---------------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------------
  a_queue_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CNT_W'(RES_DEPTH))
    else $error("result queue overflow");

  a_tls_sticky: assert property (@(posedge clk) disable iff (rst)
    tls_detected |=> tls_detected)
    else $error("TLS detection lost");

  a_rec0_sticky: assert property (@(posedge clk) disable iff (rst)
    (phase[0] == PH_RECORD) |=> (phase[0] == PH_RECORD))
    else $error("direction 0 left record parsing");

  a_rec1_sticky: assert property (@(posedge clk) disable iff (rst)
    (phase[1] == PH_RECORD) |=> (phase[1] == PH_RECORD))
    else $error("direction 1 left record parsing");

  a_record_needs_tls: assert property (@(posedge clk) disable iff (rst)
    ((phase[0] == PH_RECORD) || (phase[1] == PH_RECORD)) |-> tls_detected)
    else $error("record parsing without TLS detection");

endmodule
